@@ hw/rtl/pwmso_pkg.sv @@
// Shared types and constants for the multichannel PWM shift-out unit.
package pwmso_pkg;

    localparam int unsigned CHANNELS_DEF = 16;
    localparam int unsigned LEVELS_DEF   = 20;

    localparam int unsigned CH_FIELD_W   = 4;
    localparam int unsigned DUTY_W       = 8;
    localparam int unsigned TICK_W       = 16;

    localparam int unsigned QDEPTH       = 4;
    localparam int unsigned QPTR_W       = 2;

    localparam int unsigned APB_ADDR_W   = 3;
    localparam int unsigned APB_DATA_W   = 32;
    localparam int unsigned REG_IDX_W    = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_TICKS = '0;

    localparam logic [TICK_W-1:0] FRAME_TICKS_RST = 16'd1;

    localparam logic OP_SET_DUTY = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    typedef enum logic {
        ENT_DUTY,
        ENT_FRAME
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t             kind;
        logic [CH_FIELD_W-1:0]   channel;
        logic [DUTY_W-1:0]       duty;
    } entry_t;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } back_state_t;

endpackage

@@ hw/rtl/multichannel_pwm_shift_out_unit.sv @@
// Multichannel PWM shift-out unit. Input beats are either duty writes (op 0) or one-millisecond
// ticks (op 1); every frame_ticks ticks a frame ends and the unit sends one output beat per
// channel, highest channel first, with latch set on channel 0, then steps the PWM level.
// Duty writes and ordinary ticks are taken whenever the four-entry queue has room.
// A frame-ending tick occupies the frame engine for a pickup step and then one duty-store read per
// channel, with a single shared comparator; output stalls hold the engine.
// The duty store reads as zero after reset. frame_ticks sits at byte address 0 of the APB port.
module multichannel_pwm_shift_out_unit #(
    parameter int unsigned CHANNELS = pwmso_pkg::CHANNELS_DEF,
    parameter int unsigned LEVELS   = pwmso_pkg::LEVELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pwmso_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pwmso_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pwmso_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                op,
    input  logic [pwmso_pkg::CH_FIELD_W-1:0]    channel,
    input  logic [pwmso_pkg::DUTY_W-1:0]        duty,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                serial_bit,
    output logic [pwmso_pkg::CH_FIELD_W-1:0]    bit_channel,
    output logic                                latch
);
    import pwmso_pkg::*;

    logic [TICK_W-1:0] frame_ticks_reg;
    logic              reg_hit;
    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_not_empty;
    entry_t            q_data;
    entry_t            q_head;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_FRAME_TICKS);
    assign prdata  = reg_hit ? APB_DATA_W'(frame_ticks_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ticks_reg <= FRAME_TICKS_RST;
        end
        else if (psel && penable && pwrite && reg_hit)
        begin
            frame_ticks_reg <= pwdata[TICK_W-1:0];
        end
    end

    pwmso_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .channel     (channel),
        .duty        (duty),
        .frame_ticks (frame_ticks_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_data)
    );

    pwmso_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    pwmso_back #(
        .CHANNELS (CHANNELS),
        .LEVELS   (LEVELS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .serial_bit  (serial_bit),
        .bit_channel (bit_channel),
        .latch       (latch)
    );

endmodule

@@ hw/rtl/pwmso_front.sv @@
// Front end: accepts input beats, counts ticks and queues duty writes and frame ends.
module pwmso_front #(
    parameter int unsigned CHANNELS = pwmso_pkg::CHANNELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                op,
    input  logic [pwmso_pkg::CH_FIELD_W-1:0]    channel,
    input  logic [pwmso_pkg::DUTY_W-1:0]        duty,
    input  logic [pwmso_pkg::TICK_W-1:0]        frame_ticks,
    input  logic                                q_full,
    output logic                                q_push,
    output pwmso_pkg::entry_t                   q_data
);
    import pwmso_pkg::*;

    logic [TICK_W-1:0] tick_count_reg;
    logic [TICK_W-1:0] tick_count_next;
    logic [TICK_W-1:0] tick_inc;
    logic              accept;
    logic              frame_end;
    logic              chan_ok;

    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;
    assign tick_inc  = tick_count_reg + 1'b1;
    assign frame_end = (tick_inc >= frame_ticks);
    assign chan_ok   = (32'(channel) < CHANNELS);

    always_comb
    begin
        tick_count_next = tick_count_reg;
        q_push          = 1'b0;
        q_data.kind     = ENT_DUTY;
        q_data.channel  = channel;
        q_data.duty     = duty;
        if (accept)
        begin
            if (op == OP_TICK)
            begin
                q_data.kind = ENT_FRAME;
                if (frame_end)
                begin
                    tick_count_next = '0;
                    q_push          = 1'b1;
                end
                else
                begin
                    tick_count_next = tick_inc;
                end
            end
            else
            begin
                // drop writes to channels that do not exist
                q_push = chan_ok;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
        end
    end

endmodule

@@ hw/rtl/pwmso_queue.sv @@
// Small FIFO between the front end and the frame engine.
module pwmso_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pwmso_pkg::entry_t   push_data,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output pwmso_pkg::entry_t   head
);
    import pwmso_pkg::*;

    entry_t             slot_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;
    logic [QPTR_W:0]    count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ hw/rtl/pwmso_back.sv @@
// Frame engine: holds the duty store, applies writes and shifts out one bit per channel.
module pwmso_back #(
    parameter int unsigned CHANNELS = pwmso_pkg::CHANNELS_DEF,
    parameter int unsigned LEVELS   = pwmso_pkg::LEVELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_not_empty,
    input  pwmso_pkg::entry_t                   q_head,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                serial_bit,
    output logic [pwmso_pkg::CH_FIELD_W-1:0]    bit_channel,
    output logic                                latch
);
    import pwmso_pkg::*;

    localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned LV_W = $clog2(LEVELS);

    logic [DUTY_W-1:0]  thr_tab [LEVELS];

    genvar g;
    generate
        for (g = 0; g < LEVELS; g++)
        begin : g_thr
            localparam int unsigned TH = (g * 255) / (LEVELS - 1);
            assign thr_tab[g] = TH[DUTY_W-1:0];
        end
    endgenerate

    logic [DUTY_W-1:0]  duty_mem [CHANNELS];
    logic [CHANNELS-1:0] written_reg;

    back_state_t        state_reg, state_next;
    logic [CH_W-1:0]    cnt_reg, cnt_next;
    logic [LV_W-1:0]    level_reg, level_next;
    logic [DUTY_W-1:0]  thr_reg, thr_next;

    logic               rd_vld_reg, rd_vld_next;
    logic [CH_W-1:0]    rd_ch_reg;
    logic [DUTY_W-1:0]  rd_thr_reg;
    logic [DUTY_W-1:0]  rd_duty_reg;
    logic               rd_written_reg;

    logic               out_vld_reg;
    logic               out_bit_reg;
    logic [CH_FIELD_W-1:0] out_ch_reg;
    logic               out_latch_reg;

    logic               out_free;
    logic               rd_adv;
    logic               issue;
    logic               duty_wr;
    logic [CH_W-1:0]    wr_addr;
    logic [DUTY_W-1:0]  rd_duty_eff;

    assign out_valid   = out_vld_reg;
    assign serial_bit  = out_bit_reg;
    assign bit_channel = out_ch_reg;
    assign latch       = out_latch_reg;

    assign out_free    = !out_vld_reg || !out_stall;
    assign rd_adv      = rd_vld_reg && out_free;
    assign wr_addr     = CH_W'(q_head.channel);
    assign rd_duty_eff = rd_written_reg ? rd_duty_reg : '0;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        level_next  = level_reg;
        thr_next    = thr_reg;
        q_pop       = 1'b0;
        duty_wr     = 1'b0;
        issue       = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop = 1'b1;
                    if (q_head.kind == ENT_DUTY)
                    begin
                        duty_wr = 1'b1;
                    end
                    else
                    begin
                        state_next = BK_EMIT;
                        cnt_next   = CH_W'(CHANNELS - 1);
                        thr_next   = thr_tab[level_reg];
                        level_next = (level_reg == LV_W'(LEVELS - 1)) ? '0
                                                                       : level_reg + 1'b1;
                    end
                end
            end
            BK_EMIT:
            begin
                // read the next channel once the read stage can move on
                if (!rd_vld_reg || rd_adv)
                begin
                    issue = 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
        rd_vld_next = issue ? 1'b1 : (rd_adv ? 1'b0 : rd_vld_reg);
    end

    always_ff @(posedge clk)
    begin
        if (duty_wr)
        begin
            duty_mem[wr_addr] <= q_head.duty;
        end
        if (issue)
        begin
            rd_duty_reg <= duty_mem[cnt_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_ch_reg      <= cnt_reg;
            rd_thr_reg     <= thr_reg;
            rd_written_reg <= written_reg[cnt_reg];
        end
        if (rd_adv)
        begin
            out_bit_reg   <= (rd_duty_eff >= rd_thr_reg);
            out_ch_reg    <= CH_FIELD_W'(rd_ch_reg);
            out_latch_reg <= (rd_ch_reg == '0);
        end
        thr_reg <= thr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            cnt_reg     <= '0;
            level_reg   <= '0;
            written_reg <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            level_reg  <= level_next;
            rd_vld_reg <= rd_vld_next;
            if (duty_wr)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_adv)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

endmodule

@@ tb/sv/tb.sv @@
// Testbench for the multichannel PWM shift-out unit: predicted serial frames, APB setup, random flow.
`timescale 1ns / 100ps

module tb;
    import pwmso_pkg::*;

    localparam int DRAIN_CYCLES = 120;
    localparam int PHASE_BEATS  = 36;

    typedef struct {
        logic                  lit;
        logic [CH_FIELD_W-1:0] chan;
        logic                  last;
    } pwm_bit_t;

    // Tracks duty store, level and tick count; holds the serial bits still due.
    class pwm_bits_board;
        logic [DUTY_W-1:0] duty_mem [CHANNELS_DEF];
        int unsigned       level;
        logic [TICK_W-1:0] tick_cnt;
        logic [TICK_W-1:0] frame_len;
        pwm_bit_t          due_bits [$];
        int                errors;

        function new();
            foreach (duty_mem[i])
                duty_mem[i] = '0;
            level     = 0;
            tick_cnt  = '0;
            frame_len = FRAME_TICKS_RST;
            errors    = 0;
        endfunction

        function void set_frame_len(logic [TICK_W-1:0] v);
            frame_len = v;
        endfunction

        function void take_beat(logic op_v, logic [CH_FIELD_W-1:0] ch, logic [DUTY_W-1:0] dv);
            int unsigned thr;
            pwm_bit_t    b;
            if (op_v == OP_SET_DUTY)
            begin
                if (ch < CHANNELS_DEF)
                    duty_mem[ch] = dv;
                return;
            end
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt < frame_len)
                return;
            tick_cnt = '0;
            thr = (level * 255) / (LEVELS_DEF - 1);
            for (int c = int'(CHANNELS_DEF) - 1; c >= 0; c--)
            begin
                b.lit  = (duty_mem[c] >= thr);
                b.chan = CH_FIELD_W'(c);
                b.last = (c == 0);
                due_bits.push_back(b);
            end
            level = (level + 1 >= LEVELS_DEF) ? 0 : level + 1;
        endfunction

        task report_mismatch(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task match_bit(logic lit, logic [CH_FIELD_W-1:0] ch, logic last);
            pwm_bit_t e;
            if (due_bits.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat ch %0d bit %0b latch %0b",
                                          ch, lit, last));
                return;
            end
            e = due_bits.pop_front();
            if (lit !== e.lit)
                report_mismatch($sformatf("serial_bit ch %0d: got %b want %b", e.chan, lit, e.lit));
            if (ch !== e.chan)
                report_mismatch($sformatf("bit_channel: got %0d want %0d", ch, e.chan));
            if (last !== e.last)
                report_mismatch($sformatf("latch ch %0d: got %b want %b", e.chan, last, e.last));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic                  op;
    logic [CH_FIELD_W-1:0] channel;
    logic [DUTY_W-1:0]     duty;
    logic                  out_valid;
    logic                  out_stall;
    logic                  serial_bit;
    logic [CH_FIELD_W-1:0] bit_channel;
    logic                  latch;

    pwm_bits_board board;
    bit            gaps_on;

    multichannel_pwm_shift_out_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .channel     (channel),
        .duty        (duty),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .serial_bit  (serial_bit),
        .bit_channel (bit_channel),
        .latch       (latch)
    );

    always #5 clk = ~clk;

    // Present one beat, hold it until taken, then feed the predictor.
    task send_beat(logic op_v, logic [CH_FIELD_W-1:0] ch, logic [DUTY_W-1:0] dv);
        int n;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= op_v;
        channel  <= ch;
        duty     <= dv;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        board.take_beat(op_v, ch, dv);
    endtask

    task send_random_beat();
        logic [DUTY_W-1:0] dv;
        dv = DUTY_W'($urandom);
        case ($urandom_range(0, 7))
            0: dv = 8'd0;
            1: dv = 8'd255;
            2: dv = 8'd1;
            3: dv = 8'd254;
            default: ;
        endcase
        send_beat(($urandom_range(0, 4) < 3) ? OP_TICK : OP_SET_DUTY,
                  CH_FIELD_W'($urandom_range(0, CHANNELS_DEF - 1)), dv);
    endtask

    // Wait until every due bit is out and any queued ticks have drained.
    task settle();
        in_valid <= 1'b0;
        while (board.due_bits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task write_frame_ticks(logic [APB_DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_FRAME_TICKS, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (pready)
                break;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_frame_len(v[TICK_W-1:0]);
        @(posedge clk);
    endtask

    // Output side: check every taken beat, stall in random bursts.
    initial
    begin
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                board.match_bit(serial_bit, bit_channel, latch);
            if (gaps_on && stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 10);
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int unsigned settings [4];
        clk       = 1'b0;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        op        = OP_SET_DUTY;
        channel   = '0;
        duty      = '0;
        out_stall = 1'b0;
        gaps_on   = 1'b1;
        board     = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Duty extremes and the level-one boundary, then a full sweep of levels.
        send_beat(OP_SET_DUTY, 4'd15, 8'd255);
        send_beat(OP_SET_DUTY, 4'd0, 8'd0);
        send_beat(OP_SET_DUTY, 4'd7, 8'd1);
        send_beat(OP_SET_DUTY, 4'd8, 8'd254);
        send_beat(OP_SET_DUTY, 4'd3, 8'd13);
        repeat (LEVELS_DEF) send_beat(OP_TICK, 4'd0, 8'd0);
        settle();

        // Zero frame length behaves as one.
        write_frame_ticks(32'd0);
        send_beat(OP_TICK, 4'd5, 8'd0);
        send_beat(OP_SET_DUTY, 4'd5, 8'd200);
        send_beat(OP_TICK, 4'd0, 8'd0);
        settle();

        // Longest frame, then lower it below the count already reached.
        write_frame_ticks(32'hFFFF_FFFF);
        repeat (6) send_beat(OP_TICK, 4'd0, 8'd0);
        send_beat(OP_SET_DUTY, 4'd10, 8'd128);
        settle();
        write_frame_ticks(32'h0003_0003);
        repeat (2) send_beat(OP_TICK, 4'd0, 8'd0);
        settle();

        settings[0] = 2;
        settings[1] = 1;
        settings[2] = $urandom_range(3, 6);
        settings[3] = 1;
        for (int p = 0; p < 4; p++)
        begin
            write_frame_ticks({$urandom_range(0, 65535) & 32'hFFFF_0000} | settings[p]);
            if (p == 3)
                gaps_on = 1'b0;
            repeat (PHASE_BEATS) send_random_beat();
            settle();
        end

        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
